@@ rtl/wfu_pkg.sv @@
// shared types and constants for the websocket frame unmasker
// no dependencies
package wfu_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic       last_of_frame;
    } result_t;

    localparam logic [2:0] ST_PAYLOAD = 3'd0;
    localparam logic [2:0] ST_CLOSE   = 3'd1;
    localparam logic [2:0] ST_BADOP   = 3'd2;
    localparam logic [2:0] ST_BADLEN  = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam logic [7:0] OP_TEXT_FINAL = 8'd129;
    localparam logic [7:0] OP_CLOSE      = 8'd136;
    localparam logic [6:0] LEN_FIELD     = 7'h7F;
    localparam logic [6:0] LEN_MAX_SHORT = 7'd125;

endpackage

@@ rtl/wfu_parser.sv @@
// frame parser: phase, mask key, length and mask position state
// one byte per step; depends on wfu_pkg
module wfu_parser
    import wfu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output logic    has_result,
    output result_t result
);

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_LEN     = 3'd1,
        PH_MASK    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DISCARD = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [6:0]  bytes_left_reg, bytes_left_next;
    logic [1:0]  mask_pos_reg, mask_pos_next;
    logic [7:0]  mask_byte;
    logic [6:0]  len;

    assign len       = item.rx_byte[6:0] & LEN_FIELD;
    assign mask_byte = mask_key_reg[{mask_pos_reg, 3'b000} +: 8];

    always_comb
    begin
        phase_eff       = item.frame_start ? PH_WAIT : phase_reg;
        phase_next      = phase_eff;
        mask_key_next   = mask_key_reg;
        bytes_left_next = bytes_left_reg;
        mask_pos_next   = mask_pos_reg;
        has_result      = 1'b0;
        result          = '{payload_byte: 8'd0, status: ST_PAYLOAD, last_of_frame: 1'b1};
        case (phase_eff)
            PH_WAIT:
            begin
                if (item.rx_byte == OP_TEXT_FINAL)
                begin
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next    = PH_DISCARD;
                    has_result    = 1'b1;
                    result.status = (item.rx_byte == OP_CLOSE) ? ST_CLOSE : ST_BADOP;
                end
            end
            PH_LEN:
            begin
                if (len > LEN_MAX_SHORT)
                begin
                    phase_next    = PH_DISCARD;
                    has_result    = 1'b1;
                    result.status = ST_BADLEN;
                end
                else
                begin
                    bytes_left_next = len;
                    mask_pos_next   = 2'd0;
                    mask_key_next   = 32'd0;
                    phase_next      = PH_MASK;
                end
            end
            PH_MASK:
            begin
                mask_key_next[{mask_pos_reg, 3'b000} +: 8] = item.rx_byte;
                mask_pos_next = mask_pos_reg + 2'd1;
                if (mask_pos_reg == 2'd3)
                begin
                    if (bytes_left_reg == 7'd0)
                    begin
                        phase_next    = PH_WAIT;
                        has_result    = 1'b1;
                        result.status = ST_EMPTY;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                mask_pos_next        = mask_pos_reg + 2'd1;
                bytes_left_next      = bytes_left_reg - 7'd1;
                has_result           = 1'b1;
                result.payload_byte  = item.rx_byte ^ mask_byte;
                result.last_of_frame = (bytes_left_reg == 7'd1);
                if (bytes_left_reg == 7'd1)
                begin
                    phase_next = PH_WAIT;
                end
            end
            default:
            begin
                phase_next = PH_DISCARD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            mask_key_reg   <= 32'd0;
            bytes_left_reg <= 7'd0;
            mask_pos_reg   <= 2'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            mask_key_reg   <= mask_key_next;
            bytes_left_reg <= bytes_left_next;
            mask_pos_reg   <= mask_pos_next;
        end
    end

endmodule

@@ rtl/wfu_out_reg.sv @@
// result register holding one transaction for the downstream side
// depends on wfu_pkg
module wfu_out_reg
    import wfu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    load_valid,
    input  result_t load_data,
    input  logic    result_stall,
    output logic    busy,
    output logic    result_valid,
    output result_t result
);

    logic    valid_reg;
    result_t data_reg;

    // full and not taken this cycle
    assign busy         = valid_reg && result_stall;
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= load_valid;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
        begin
            data_reg <= load_data;
        end
    end

endmodule

@@ rtl/websocket_frame_unmasker.sv @@
// top level of the websocket frame unmasker
// depends on wfu_pkg, wfu_parser and wfu_out_reg
//
// item channel: one received byte a transaction, with frame_start marking a
// first header byte. result channel: unmasked payload bytes or a status
// (close, bad opcode, unsupported length, empty frame), last_of_frame set on
// the final payload byte and on every status. a byte that causes no result
// (header, length, mask, discarded) shows nothing on the result channel.
// path: an accepted byte is held in the input register, then parsed on its
// way into the result register once that register is not busy, and its
// result shows on result_valid once it has been loaded there.
// throughput: one byte per cycle while the result side does not stall; the
// parser state update and one xor sit between the two registers.
// reset: parser waits for a first header byte, mask key and counters clear,
// both registers empty.
// stall: while a result waits under result_stall the input register holds
// its byte and item_stall rises once it is also full.
module websocket_frame_unmasker
    import wfu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    in_valid_reg;
    item_t   in_data_reg;
    logic    advance;
    logic    out_busy;
    logic    has_result;
    result_t parsed;

    assign advance    = in_valid_reg && !out_busy;
    assign item_stall = in_valid_reg && out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            in_data_reg <= item;
        end
    end

    wfu_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (in_data_reg),
        .has_result (has_result),
        .result     (parsed)
    );

    wfu_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .load_valid   (has_result),
        .load_data    (parsed),
        .result_stall (result_stall),
        .busy         (out_busy),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ rtl/wfu_checker.sv @@
// port-level checks for the websocket frame unmasker, bound to the top level
// depends on wfu_pkg
module wfu_port_checker
    import wfu_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_PAYLOAD |-> result.last_of_frame)
        else $error("status result without last_of_frame");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_PAYLOAD |-> result.payload_byte == 8'd0)
        else $error("status result with nonzero payload byte");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status == ST_PAYLOAD || result.status == ST_CLOSE
            || result.status == ST_BADOP || result.status == ST_BADLEN
            || result.status == ST_EMPTY)
        else $error("status code out of range");

endmodule

bind websocket_frame_unmasker wfu_port_checker u_wfu_checker (.*);

@@ bench/wfu_checker.sv @@
// checker for the websocket frame unmasker: follows both channels, predicts the
// result of every accepted byte transaction and compares it with the block's output
// depends on wfu_pkg
`timescale 1ns / 100ps

module wfu_checker
    import wfu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      mismatches,
    output int      pending
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    phase_t      phase;
    logic [31:0] mask_key;
    logic [6:0]  bytes_left;
    logic [1:0]  mask_pos;
    result_t     unmasked_q[$];
    int          miss_cnt;

    // advances the parser by one byte, returns 1 when the byte causes a result
    function automatic bit unmask_step(input item_t it, output result_t res);
        bit         hit;
        logic [6:0] len;
        hit = 1'b0;
        res = '0;
        len = it.rx_byte[6:0] & LEN_FIELD;
        if (it.frame_start)
            phase = PH_WAIT;
        case (phase)
            PH_WAIT:
            begin
                if (it.rx_byte == OP_TEXT_FINAL)
                    phase = PH_LEN;
                else
                begin
                    phase = PH_DISCARD;
                    hit = 1'b1;
                    res.status = (it.rx_byte == OP_CLOSE) ? ST_CLOSE : ST_BADOP;
                    res.last_of_frame = 1'b1;
                end
            end
            PH_LEN:
            begin
                if (len > LEN_MAX_SHORT)
                begin
                    phase = PH_DISCARD;
                    hit = 1'b1;
                    res.status = ST_BADLEN;
                    res.last_of_frame = 1'b1;
                end
                else
                begin
                    bytes_left = len;
                    mask_pos = 2'd0;
                    mask_key = '0;
                    phase = PH_MASK;
                end
            end
            PH_MASK:
            begin
                mask_key[8 * mask_pos +: 8] = it.rx_byte;
                if (mask_pos == 2'd3)
                begin
                    mask_pos = 2'd0;
                    if (bytes_left == 7'd0)
                    begin
                        // empty frame reports on the last key byte
                        phase = PH_WAIT;
                        hit = 1'b1;
                        res.status = ST_EMPTY;
                        res.last_of_frame = 1'b1;
                    end
                    else
                        phase = PH_PAYLOAD;
                end
                else
                    mask_pos = mask_pos + 2'd1;
            end
            PH_PAYLOAD:
            begin
                hit = 1'b1;
                res.payload_byte = it.rx_byte ^ mask_key[8 * mask_pos +: 8];
                res.status = ST_PAYLOAD;
                mask_pos = mask_pos + 2'd1;
                bytes_left = bytes_left - 7'd1;
                res.last_of_frame = (bytes_left == 7'd0);
                if (bytes_left == 7'd0)
                    phase = PH_WAIT;
            end
            default:
                phase = PH_DISCARD;
        endcase
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            phase = PH_WAIT;
            mask_key = '0;
            bytes_left = '0;
            mask_pos = '0;
            unmasked_q.delete();
            miss_cnt = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            // a result never stems from the byte accepted at the same edge
            if (result_valid && !result_stall)
            begin
                if (unmasked_q.size() == 0)
                begin
                    if (miss_cnt < 10)
                        $display("%t: result with none expected: byte %h status %0d last %b",
                                 $realtime, result.payload_byte, result.status,
                                 result.last_of_frame);
                    miss_cnt++;
                end
                else
                begin
                    want = unmasked_q.pop_front();
                    if (result.payload_byte !== want.payload_byte ||
                        result.status !== want.status ||
                        result.last_of_frame !== want.last_of_frame)
                    begin
                        if (miss_cnt < 10)
                            $display("%t: expected byte %h status %0d last %b,",
                                     $realtime, want.payload_byte, want.status,
                                     want.last_of_frame,
                                     " got byte %h status %0d last %b",
                                     result.payload_byte, result.status,
                                     result.last_of_frame);
                        miss_cnt++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                if (unmask_step(item, got))
                    unmasked_q.push_back(got);
            end
            mismatches <= miss_cnt;
            pending <= unmasked_q.size();
        end
    end

endmodule

@@ bench/tb_websocket_frame_unmasker.sv @@
// testbench top for the websocket frame unmasker: clock, reset, byte stimulus,
// result-side stalls and the final verdict
// depends on wfu_pkg, websocket_frame_unmasker and wfu_checker
`timescale 1ns / 100ps

module tb_websocket_frame_unmasker;
    import wfu_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      mismatches;
    int      pending;

    int      sent;
    bit      calm;
    bit      hold_req;

    websocket_frame_unmasker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    wfu_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: short stall bursts, free stretches and one long hold-off
    initial
    begin
        result_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (150) @(posedge clk);
                result_stall <= 1'b0;
                hold_req = 1'b0;
                @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(30, 80)) @(posedge clk);
            else
                @(posedge clk);
        end
    end

    // offers one byte and returns once the transaction has gone through
    task automatic push_byte(input logic [7:0] b, input logic fs);
        item_valid <= 1'b1;
        item <= '{rx_byte: b, frame_start: fs};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // mostly well-formed text frames, the rest close, bad opcode, long length
    // and cut-off frames, with trailing junk that the parser throws away
    task automatic send_random_frame();
        int         kind;
        int         len;
        int         junk;
        int         stop;
        logic [7:0] lb;
        logic [7:0] frame_q[$];
        kind = $urandom_range(0, 99);
        junk = $urandom_range(0, 3);
        lb = 8'($urandom_range(0, 255));
        if (kind < 78)
        begin
            stop = $urandom_range(0, 9);
            if (stop < 7)
                len = $urandom_range(0, 8);
            else if (stop < 9)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 125);
            lb[6:0] = 7'(len);
            frame_q.push_back(OP_TEXT_FINAL);
            frame_q.push_back(lb);
            repeat (4 + len) frame_q.push_back(8'($urandom_range(0, 255)));
            junk = 0;
            // cut the frame short, the next header marked with frame_start resyncs the parser
            if ($urandom_range(0, 11) == 0)
            begin
                stop = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > stop)
                    void'(frame_q.pop_back());
            end
        end
        else if (kind < 86)
        begin
            lb[6:0] = 7'($urandom_range(126, 127));
            frame_q.push_back(OP_TEXT_FINAL);
            frame_q.push_back(lb);
        end
        else if (kind < 92)
            frame_q.push_back(OP_CLOSE);
        else
            frame_q.push_back(lb);
        foreach (frame_q[i])
            push_byte(frame_q[i], (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0);
        sent += frame_q.size();
        repeat (junk) push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial
    begin
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        sent = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header without marker while waiting, then a two byte frame
        push_byte(OP_TEXT_FINAL, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // close, then a byte dropped while discarding
        push_byte(OP_CLOSE, 1'b1);
        push_byte(OP_TEXT_FINAL, 1'b0);
        push_byte(8'h00, 1'b1);
        // both extended length codes
        push_byte(OP_TEXT_FINAL, 1'b1);
        push_byte(8'hFE, 1'b0);
        push_byte(OP_TEXT_FINAL, 1'b1);
        push_byte(8'h7F, 1'b0);
        // empty frame
        push_byte(OP_TEXT_FINAL, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0);
        push_byte(8'h78, 1'b0);
        // longest short frame, abandoned inside the key by a new header
        push_byte(OP_TEXT_FINAL, 1'b0);
        push_byte(8'h7D, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'hFF, 1'b1);

        while (sent < 1900)
        begin
            if (sent > 1650)
                calm = 1'b1;
            if (!hold_done && sent >= 500)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sent >= 1100)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
                pause_done = 1'b1;
            end
            send_random_frame();
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
